>>> rtl/mfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared constants, types and codes of the monochrome framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_SIZE    = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_SIZE);

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    K_CLEAR   = 3'd0,
    K_PIXEL   = 3'd1,
    K_OUTLINE = 3'd2,
    K_FILL    = 3'd3,
    K_BITMAP  = 3'd4,
    K_READ    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic       pixel_value;
    logic [7:0] bitmap_byte;
    logic [7:0] image_width;
    logic [7:0] image_row;
    logic [4:0] byte_col;
    logic       invert;
    logic [9:0] read_index;
  } cmd_t;

  // per-byte write plan from the mask unit
  typedef struct packed {
    logic              en;
    logic [7:0]        mask;
    logic [7:0]        value;
    logic              clip;
    logic [ADDR_W-1:0] addr;
  } mask_t;

endpackage

>>> rtl/mfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mfb_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_mask
// Works out which bits of one framebuffer byte a command touches, their
// values, the byte address for single-byte commands and the clip flag.
// ----------------------------------------------------------------------------
module mfb_mask (
  input  logic [2:0]      kind,
  input  mfb_pkg::cmd_t   cmd,
  input  logic [7:0]      row,
  input  logic [4:0]      col,
  input  logic            pass,
  output mfb_pkg::mask_t  plan
);

  logic [7:0]  y_bm;
  logic [7:0]  xb;
  logic [4:0]  tc;
  logic [7:0]  x_sw;
  logic [7:0]  xi;
  logic [7:0]  colb;
  logic        in_x;
  logic        in_y;
  logic        on;
  logic        px_on;
  logic [13:0] a_px;
  logic [13:0] a_bm;

  always_comb begin
    y_bm  = cmd.y0 + cmd.image_row;
    xb    = cmd.x0 + {cmd.byte_col, 3'b000};
    tc    = xb[7:3] + {4'b0000, pass};
    px_on = ({1'b0, cmd.x0} < 9'(mfb_pkg::SCREEN_WIDTH)) &&
            ({1'b0, cmd.y0} < 9'(mfb_pkg::SCREEN_HEIGHT));
    a_px  = 14'(cmd.y0) * 14'(mfb_pkg::ROW_BYTES) + 14'(cmd.x0[7:3]);
    a_bm  = 14'(y_bm) * 14'(mfb_pkg::ROW_BYTES) + 14'(tc);
    in_y  = (cmd.y0 <= row) && (row <= cmd.y1);
    plan  = '0;
    x_sw  = '0;
    xi    = '0;
    colb  = '0;
    in_x  = 1'b0;
    on    = 1'b0;
    case (kind) inside
      mfb_pkg::K_CLEAR: begin
        plan.mask = 8'hFF;
      end
      mfb_pkg::K_FILL, mfb_pkg::K_OUTLINE: begin
        plan.value = 8'hFF;
        for (int i = 0; i < 8; i++) begin
          x_sw = {col, 3'(i)};
          in_x = (cmd.x0 <= x_sw) && (x_sw <= cmd.x1);
          on   = {1'b0, x_sw} < 9'(mfb_pkg::SCREEN_WIDTH);
          if (kind == mfb_pkg::K_FILL) begin
            plan.mask[i] = on && in_x && in_y;
          end else begin
            plan.mask[i] = on &&
              (((cmd.x0 <= cmd.x1) && in_x && ((row == cmd.y0) || (row == cmd.y1))) ||
               ((cmd.y0 <= cmd.y1) && in_y && ((x_sw == cmd.x0) || (x_sw == cmd.x1))));
          end
        end
      end
      mfb_pkg::K_PIXEL: begin
        plan.en    = px_on;
        plan.clip  = !px_on;
        plan.mask  = px_on ? (8'h01 << cmd.x0[2:0]) : 8'h00;
        plan.value = cmd.pixel_value ? 8'hFF : 8'h00;
        plan.addr  = mfb_pkg::ADDR_W'(a_px);
      end
      mfb_pkg::K_BITMAP: begin
        for (int i = 0; i < 8; i++) begin
          colb = {cmd.byte_col, 3'(i)};
          xi   = xb + 8'(i);
          on   = ({1'b0, xi} < 9'(mfb_pkg::SCREEN_WIDTH)) &&
                 ({1'b0, y_bm} < 9'(mfb_pkg::SCREEN_HEIGHT));
          if (colb < cmd.image_width) begin
            if (!on) begin
              plan.clip = 1'b1;
            end else if (xi[7:3] == tc) begin
              plan.mask[xi[2:0]]  = 1'b1;
              plan.value[xi[2:0]] = cmd.bitmap_byte[7-i] ^ cmd.invert;
            end
          end
        end
        plan.en   = |plan.mask;
        plan.addr = mfb_pkg::ADDR_W'(a_bm);
      end
      default: begin
        plan = '0;
      end
    endcase
  end

endmodule

>>> rtl/mono_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// 128x64 one-bit framebuffer in a byte RAM with pixel, rectangle, bitmap,
// clear and read commands, read-modify-write through the RAM's two ports.
// ----------------------------------------------------------------------------
// Clear, outline and fill sweep every byte once. Pixel and read go through
// the read and the write state; a bitmap byte reads and writes two bytes.
// The next request is taken once the result has moved to the output
// register. For clear, outline and fill the sweep over the RAM sets the rate.
// After reset the RAM is cleared by a sweep during which no request is taken.
module mono_framebuffer_draw_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x0, y0, x1, y1, pixel_value, bitmap_byte, image_width, image_row,
  // byte_col, invert, read_index, zero pad
  input  logic [79:0] s_tdata,
  // kind
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data, clipped, zero pad
  output logic [15:0] m_tdata
);

  localparam int AW = mfb_pkg::ADDR_W;

  mfb_pkg::state_t state, state_next;
  mfb_pkg::cmd_t   cmd;
  mfb_pkg::mask_t  plan;

  logic [AW-1:0] cnt;
  logic [7:0]    row;
  logic [4:0]    col;
  logic          issue_done;
  logic          p_valid;
  logic [AW-1:0] p_addr;
  logic [7:0]    p_row;
  logic [4:0]    p_col;
  logic          pass;
  logic          clip;
  logic [7:0]    rdata;
  logic [7:0]    ram_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [2:0]    mask_kind;
  logic          accept;
  logic          sweeping;
  logic          rect_clip;
  logic          read_ok;
  logic [7:0]    out_data;
  logic          out_clip;

  assign accept   = s_tvalid && s_tready;
  assign sweeping = (state == mfb_pkg::S_INIT) || (state == mfb_pkg::S_SWEEP);
  assign mask_kind = (state == mfb_pkg::S_INIT) ? mfb_pkg::K_CLEAR : cmd.kind;
  assign read_ok  = 14'(cmd.read_index) < 14'(mfb_pkg::STORE_SIZE);

  mfb_mask u_mask (
    .kind (mask_kind),
    .cmd  (cmd),
    .row  (p_row),
    .col  (p_col),
    .pass (pass),
    .plan (plan)
  );

  mfb_ram #(.WIDTH(8), .DEPTH(mfb_pkg::STORE_SIZE)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // clip of a whole rectangle, known from its corners
  always_comb begin
    logic x_ok, y_ok, x0_off, x1_off, y0_off, y1_off;
    x_ok   = s_tdata[7:0] <= s_tdata[23:16];
    y_ok   = s_tdata[15:8] <= s_tdata[31:24];
    x0_off = {1'b0, s_tdata[7:0]}   >= 9'(mfb_pkg::SCREEN_WIDTH);
    x1_off = {1'b0, s_tdata[23:16]} >= 9'(mfb_pkg::SCREEN_WIDTH);
    y0_off = {1'b0, s_tdata[15:8]}  >= 9'(mfb_pkg::SCREEN_HEIGHT);
    y1_off = {1'b0, s_tdata[31:24]} >= 9'(mfb_pkg::SCREEN_HEIGHT);
    case (s_tuser)
      mfb_pkg::K_FILL:    rect_clip = x_ok && y_ok && (x1_off || y1_off);
      mfb_pkg::K_OUTLINE: rect_clip = (x_ok && (x1_off || y0_off || y1_off)) ||
                                      (y_ok && (y1_off || x0_off || x1_off));
      default:            rect_clip = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfb_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = (state == mfb_pkg::S_IDLE);
    we         = 1'b0;
    waddr      = sweeping ? p_addr : plan.addr;
    wdata      = (ram_q & ~plan.mask) | (plan.value & plan.mask);
    raddr      = cnt;
    unique case (state)
      mfb_pkg::S_INIT, mfb_pkg::S_SWEEP: begin
        we = p_valid;
        if (issue_done && !p_valid) begin
          state_next = (state == mfb_pkg::S_INIT) ? mfb_pkg::S_IDLE : mfb_pkg::S_DONE;
        end
      end
      mfb_pkg::S_IDLE: begin
        if (accept) begin
          case (s_tuser) inside
            mfb_pkg::K_CLEAR, mfb_pkg::K_OUTLINE, mfb_pkg::K_FILL:
              state_next = mfb_pkg::S_SWEEP;
            mfb_pkg::K_PIXEL, mfb_pkg::K_BITMAP, mfb_pkg::K_READ:
              state_next = mfb_pkg::S_RD;
            default:
              state_next = mfb_pkg::S_DONE;
          endcase
        end
      end
      mfb_pkg::S_RD: begin
        raddr      = (cmd.kind == mfb_pkg::K_READ) ? AW'(14'(cmd.read_index)) : plan.addr;
        state_next = mfb_pkg::S_WR;
      end
      mfb_pkg::S_WR: begin
        we = plan.en;
        if (cmd.kind == mfb_pkg::K_BITMAP && !pass) begin
          state_next = mfb_pkg::S_RD;
        end else begin
          state_next = mfb_pkg::S_DONE;
        end
      end
      mfb_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = mfb_pkg::S_IDLE;
        end
      end
      default: state_next = mfb_pkg::S_INIT;
    endcase
  end

  // sweep address generator and write-back stage
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      issue_done <= 1'b0;
      p_valid    <= 1'b0;
    end else if (sweeping) begin
      p_valid <= !issue_done;
      if (!issue_done) begin
        p_addr <= cnt;
        p_row  <= row;
        p_col  <= col;
        cnt    <= cnt + AW'(1);
        if (col == 5'(mfb_pkg::ROW_BYTES - 1)) begin
          col <= '0;
          row <= row + 8'd1;
          if (row == 8'(mfb_pkg::SCREEN_HEIGHT - 1)) begin
            issue_done <= 1'b1;
          end
        end else begin
          col <= col + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= 1'b0;
    end else if (accept) begin
      pass <= 1'b0;
    end else if (state == mfb_pkg::S_WR) begin
      pass <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind        <= s_tuser;
      cmd.x0          <= s_tdata[7:0];
      cmd.y0          <= s_tdata[15:8];
      cmd.x1          <= s_tdata[23:16];
      cmd.y1          <= s_tdata[31:24];
      cmd.pixel_value <= s_tdata[32];
      cmd.bitmap_byte <= s_tdata[40:33];
      cmd.image_width <= s_tdata[48:41];
      cmd.image_row   <= s_tdata[56:49];
      cmd.byte_col    <= s_tdata[61:57];
      cmd.invert      <= s_tdata[62];
      cmd.read_index  <= s_tdata[72:63];
      clip            <= rect_clip;
      rdata           <= 8'h00;
    end else if (state == mfb_pkg::S_WR) begin
      if (cmd.kind == mfb_pkg::K_READ) begin
        rdata <= read_ok ? ram_q : 8'h00;
      end else begin
        clip <= clip | plan.clip;
      end
    end
  end

  // result register: hold until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mfb_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfb_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      out_data <= rdata;
      out_clip <= clip;
    end
  end

  assign m_tdata = {7'b0, out_clip, out_data};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != mfb_pkg::S_IDLE))
    else $error("engine stayed idle after a request");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (sweeping || state == mfb_pkg::S_WR))
    else $error("RAM write outside a write state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == mfb_pkg::S_DONE))
    else $error("result raised without a finished command");

endmodule
